>>> src/integer_to_radix_ascii_defines.svh
// Assertion macros used by the checker file.
`ifndef INTEGER_TO_RADIX_ASCII_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ITRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ITRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/itra_pkg.sv
package itra_pkg;

  localparam int VALUE_W     = 32;
  localparam int IN_W        = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int EXT_W       = (VALUE_W > IN_W) ? VALUE_W : IN_W;

  localparam int DIV_BITS    = 8;
  localparam int DIV_STEPS   = (VALUE_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W       = DIV_STEPS * DIV_BITS;
  localparam int STEP_CW     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int DIGIT_W     = 6;
  localparam int REM_W       = DIGIT_W + 1;
  localparam int PTR_W       = $clog2(VALUE_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

  localparam logic [DIGIT_W-1:0] DEC_BASE      = DIGIT_W'(10);
  localparam logic [DIGIT_W-1:0] MAX_DIGIT_DEC = DIGIT_W'(9);

  localparam logic [CHAR_W-1:0] CH_NONE    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;

  typedef struct packed {
    logic signed [IN_W-1:0] value;
    logic [RADIX_W-1:0]     radix;
  } itra_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              last_char;
    logic              bad_radix;
  } itra_out_t;

  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic [RADIX_W-1:0] radix;
    logic               bad;
    logic               zero;
    logic               neg;
  } itra_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } itra_state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d > MAX_DIGIT_DEC) begin
      return CHAR_W'(d - DEC_BASE) + CH_LOWER_A;
    end else begin
      return CHAR_W'(d) + CH_ZERO;
    end
  endfunction

endpackage

>>> src/itra_front.sv
module itra_front
  import itra_pkg::*;
(
  input  itra_in_t  in_data,
  input  logic      start,
  input  logic      q_full,
  output logic      push,
  output itra_cmd_t cmd
);

  logic [EXT_W-1:0]   ext;
  logic [VALUE_W-1:0] raw;

  always_comb begin
    ext       = EXT_W'(in_data.value);
    raw       = ext[VALUE_W-1:0];
    cmd.radix = in_data.radix;
    cmd.bad   = (in_data.radix < RADIX_MIN) || (in_data.radix > RADIX_MAX);
    cmd.zero  = (raw == '0);
    cmd.neg   = raw[VALUE_W-1] && (in_data.radix == RADIX_DEC);
    cmd.mag   = cmd.neg ? (~raw + VALUE_W'(1)) : raw;
    push      = start && !q_full;
  end

endmodule

>>> src/itra_queue.sv
module itra_queue
  import itra_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  itra_cmd_t push_cmd,
  input  logic      pop,
  output itra_cmd_t head,
  output logic      empty,
  output logic      full
);

  itra_cmd_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_r;
  logic [QPTR_W-1:0]  rd_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic [QCNT_W-1:0]  cnt_nxt;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (pop)  rd_r <= rd_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_cmd;
  end

  assign head  = mem_r[rd_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));

endmodule

>>> src/itra_back.sv
module itra_back
  import itra_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  itra_cmd_t head,
  input  logic      q_empty,
  output logic      pop,
  output logic      out_valid,
  output itra_out_t out_data
);

  itra_state_t         state_r, state_nxt;
  logic [DIV_W-1:0]    quo_r, quo_nxt;
  logic [DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [RADIX_W-1:0]  radix_r, radix_nxt;
  logic                neg_r, neg_nxt;
  logic [STEP_CW-1:0]  step_r, step_nxt;
  logic [PTR_W-1:0]    dig_idx_r, dig_idx_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic [DIGIT_W-1:0]  stack_r [VALUE_W];
  logic                out_valid_r, out_valid_nxt;
  itra_out_t           out_data_r, out_data_nxt;

  logic [DIV_BITS-1:0] chunk;
  logic [DIV_BITS-1:0] qbits;
  logic [REM_W-1:0]    rem_v;
  logic [DIGIT_W-1:0]  div_rem;
  logic [DIV_W-1:0]    quo_shift;
  logic                push_dig;

  always_comb begin
    chunk = quo_r[DIV_W-1 -: DIV_BITS];
    rem_v = REM_W'(rem_r);
    qbits = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      rem_v    = {rem_v[REM_W-2:0], chunk[i]};
      qbits[i] = (rem_v >= REM_W'(radix_r));
      if (qbits[i]) rem_v = rem_v - REM_W'(radix_r);
    end
    div_rem   = rem_v[DIGIT_W-1:0];
    quo_shift = DIV_W'({quo_r, qbits});
  end

  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    dig_idx_nxt   = dig_idx_r;
    ptr_nxt       = ptr_r;
    pop           = 1'b0;
    push_dig      = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (head.bad) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.ascii_char = CH_NONE;
            out_data_nxt.last_char  = 1'b1;
            out_data_nxt.bad_radix  = 1'b1;
          end else if (head.zero) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.ascii_char = CH_ZERO;
            out_data_nxt.last_char  = 1'b1;
            out_data_nxt.bad_radix  = 1'b0;
          end else begin
            quo_nxt     = DIV_W'(head.mag);
            rem_nxt     = '0;
            radix_nxt   = head.radix;
            neg_nxt     = head.neg;
            step_nxt    = '0;
            dig_idx_nxt = '0;
            state_nxt   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        quo_nxt  = quo_shift;
        rem_nxt  = div_rem;
        step_nxt = step_r + STEP_CW'(1);
        if (step_r == STEP_CW'(DIV_STEPS - 1)) begin
          push_dig    = 1'b1;
          dig_idx_nxt = dig_idx_r + PTR_W'(1);
          step_nxt    = '0;
          rem_nxt     = '0;
          if (quo_shift == '0) begin
            ptr_nxt   = dig_idx_r;
            state_nxt = neg_r ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.ascii_char = CH_MINUS;
        out_data_nxt.last_char  = 1'b0;
        out_data_nxt.bad_radix  = 1'b0;
        state_nxt               = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.ascii_char = digit_char(stack_r[ptr_r]);
        out_data_nxt.last_char  = (ptr_r == '0);
        out_data_nxt.bad_radix  = 1'b0;
        if (ptr_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r - PTR_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    radix_r    <= radix_nxt;
    neg_r      <= neg_nxt;
    step_r     <= step_nxt;
    dig_idx_r  <= dig_idx_nxt;
    ptr_r      <= ptr_nxt;
    out_data_r <= out_data_nxt;
    if (push_dig) stack_r[dig_idx_r] <= div_rem;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/integer_to_radix_ascii.sv
// Bad radix or zero value gives its one result after start is taken: the command is queued,
// then the result is registered. Otherwise the divider works out each digit (8 quotient bits
// per cycle), then the characters stream out one per cycle, sign first. A 2-entry queue
// lets start be taken while the divider works. busy is high only when the queue is full.
// Reset: synchronous, active low; clears queue, sequencer and result strobe.
module integer_to_radix_ascii
  import itra_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  itra_in_t  in_data,
  output logic      out_valid,
  output itra_out_t out_data
);

  itra_cmd_t cmd;
  itra_cmd_t head;
  logic      push;
  logic      pop;
  logic      q_empty;
  logic      q_full;

  itra_front u_front (
    .in_data (in_data),
    .start   (start),
    .q_full  (q_full),
    .push    (push),
    .cmd     (cmd)
  );

  itra_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  itra_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign busy = q_full;

endmodule

>>> src/itra_checker.sv
`include "integer_to_radix_ascii_defines.svh"

module itra_checker
  import itra_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input itra_out_t out_data
);

  logic [CHAR_W-1:0] ch;
  logic              last;
  logic              bad;
  logic              legal_char;

  assign ch = out_data.ascii_char;
  assign last = out_data.last_char;
  assign bad = out_data.bad_radix;
  assign legal_char = ((ch >= CH_ZERO) && (ch <= CH_NINE)) ||
                      ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z)) ||
                      (ch == CH_MINUS);

  `ITRA_ASSERT_NOW(a_bad_form, out_valid && bad, last && (ch == CH_NONE), "bad radix item malformed")
  `ITRA_ASSERT_NEXT(a_run, out_valid && !last, out_valid, "gap inside a character run")
  `ITRA_ASSERT_NOW(a_minus, out_valid && (ch == CH_MINUS), !last && !bad, "minus sign ends a run")
  `ITRA_ASSERT_NOW(a_charset, out_valid && !bad, legal_char, "character outside digit set")

endmodule

bind integer_to_radix_ascii itra_checker u_itra_checker (.*);
